### rtl/core/svna_pkg.sv
// ----------------------------------------------------------------------------
// svna_pkg
// Shared types and constants for the smoothed vertex normal accumulator.
// ----------------------------------------------------------------------------
package svna_pkg;

   localparam int VERTEX_DEPTH = 1024;
   localparam int SUM_BITS     = 24;
   localparam int ADDR_W       = $clog2(VERTEX_DEPTH);
   localparam int IDX_W        = 10;
   localparam int COORD_W      = 16;
   localparam int EDGE_W       = COORD_W + 1;
   localparam int PROD_W       = 2 * EDGE_W;
   localparam int NV_W         = PROD_W + 2;
   localparam int NORM_W       = 16;
   localparam int FIFO_DEPTH   = 4;

   localparam logic [1:0] CMD_WRITE    = 2'd0;
   localparam logic [1:0] CMD_TRIANGLE = 2'd1;
   localparam logic [1:0] CMD_READ     = 2'd2;

   typedef struct packed {
      logic [1:0]               command;
      logic [IDX_W-1:0]         vertex_index;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
      logic [IDX_W-1:0]         corner_a;
      logic [IDX_W-1:0]         corner_b;
      logic [IDX_W-1:0]         corner_c;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]          read_index;
      logic signed [NORM_W-1:0]  normal_x;
      logic signed [NORM_W-1:0]  normal_y;
      logic signed [NORM_W-1:0]  normal_z;
      logic                      zero_length;
   } rsp_type;

   // result of the normalize unit, component 0 is x
   typedef struct packed {
      logic                    zero;
      logic [2:0][NORM_W-1:0]  n;
   } norm_res_type;

   function automatic logic in_range(input logic [IDX_W-1:0] idx);
      return int'(idx) < VERTEX_DEPTH;
   endfunction

endpackage

### rtl/core/svna_cmd_fifo.sv
// ----------------------------------------------------------------------------
// svna_cmd_fifo
// Command queue between the request port and the execution engine.
// ----------------------------------------------------------------------------
module svna_cmd_fifo import svna_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  req_type wr_data,
   output logic    fifo_full,
   input  logic    rd_en,
   output req_type rd_data,
   output logic    fifo_empty
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);

   req_type            mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wptr_ff, wptr_in;
   logic [PTR_W-1:0]   rptr_ff, rptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic               do_wr, do_rd;

   assign fifo_full  = (count_ff == (PTR_W+1)'(FIFO_DEPTH));
   assign fifo_empty = (count_ff == '0);
   assign do_wr      = wr_en && !fifo_full;
   assign do_rd      = rd_en && !fifo_empty;
   assign rd_data    = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = do_wr ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_rd ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end

endmodule

### rtl/core/svna_norm.sv
// ----------------------------------------------------------------------------
// svna_norm
// Iterative vector normalizer: bit-serial range shift, squared length,
// digit-by-digit square root and restoring division to Q1.14.
// ----------------------------------------------------------------------------
module svna_norm import svna_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [2:0][NV_W-1:0]   vec,
   output logic                   done,
   output norm_res_type           res
);

   localparam int LEN_W = 31;
   localparam int SQ_W  = 2 * LEN_W;
   localparam int REM_W = LEN_W + 2;
   localparam int Q_W   = 15;
   localparam int NUM_W = 30 + 14 + 1;

   typedef enum logic [2:0] {
      S_IDLE, S_MAX, S_SHIFT, S_SQ, S_ROOT, S_DINIT, S_DIV
   } state_type;

   state_type             state_ff;
   logic                  done_ff;
   norm_res_type          res_ff;
   logic [2:0][NV_W-1:0]  mag_ff;
   logic [2:0]            neg_ff;
   logic [NV_W-1:0]       mx_ff;
   logic [4:0]            cnt_ff;
   logic [1:0]            comp_ff;
   logic [59:0]           sq_ff;
   logic [SQ_W-1:0]       sum_ff;
   logic [SQ_W-1:0]       rad_ff;
   logic [REM_W-1:0]      rem_ff;
   logic [LEN_W-1:0]      root_ff;
   logic [LEN_W-1:0]      rdiv_ff;
   logic [Q_W-1:0]        nlo_ff;
   logic [Q_W-1:0]        q_ff;

   logic [NV_W-1:0]       mx_in;
   logic [REM_W+1:0]      rem_t;
   logic [REM_W+1:0]      trial;
   logic [NUM_W-1:0]      num;
   logic [LEN_W:0]        r_t;
   logic [Q_W-1:0]        q_in;

   assign done = done_ff;
   assign res  = res_ff;

   always_comb begin
      mx_in = mag_ff[0];
      if (mag_ff[1] > mx_in) mx_in = mag_ff[1];
      if (mag_ff[2] > mx_in) mx_in = mag_ff[2];
      rem_t = {rem_ff, rad_ff[SQ_W-1 -: 2]};
      trial = (REM_W+2)'({root_ff, 2'b01});
      num   = NUM_W'({mag_ff[comp_ff][29:0], 14'b0}) + NUM_W'(root_ff >> 1);
      r_t   = {rdiv_ff, nlo_ff[Q_W-1]};
      q_in  = {q_ff[Q_W-2:0], (r_t >= {1'b0, root_ff})};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  for (int i = 0; i < 3; i++) begin
                     neg_ff[i] <= vec[i][NV_W-1];
                     mag_ff[i] <= vec[i][NV_W-1] ? NV_W'(0) - vec[i] : vec[i];
                  end
                  state_ff <= S_MAX;
               end
            end
            S_MAX: begin
               mx_ff    <= mx_in;
               state_ff <= S_SHIFT;
            end
            S_SHIFT: begin
               if (mx_ff == '0) begin
                  res_ff.zero <= 1'b1;
                  res_ff.n    <= '0;
                  done_ff     <= 1'b1;
                  state_ff    <= S_IDLE;
               end else if (|mx_ff[NV_W-1:30]) begin
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
                  mx_ff <= mx_ff >> 1;
               end else if (!mx_ff[29]) begin
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] << 1;
                  mx_ff <= mx_ff << 1;
               end else begin
                  cnt_ff   <= '0;
                  sum_ff   <= '0;
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               // one square per cycle, each summed in the following cycle
               if (cnt_ff < 5'd3) begin
                  sq_ff <= mag_ff[cnt_ff[1:0]][29:0] * mag_ff[cnt_ff[1:0]][29:0];
               end
               if (cnt_ff != '0) begin
                  sum_ff <= sum_ff + SQ_W'(sq_ff);
               end
               if (cnt_ff == 5'd3) begin
                  rad_ff   <= sum_ff + SQ_W'(sq_ff);
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_ROOT;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_ROOT: begin
               if (rem_t >= trial) begin
                  rem_ff  <= REM_W'(rem_t - trial);
                  root_ff <= {root_ff[LEN_W-2:0], 1'b1};
               end else begin
                  rem_ff  <= REM_W'(rem_t);
                  root_ff <= {root_ff[LEN_W-2:0], 1'b0};
               end
               rad_ff <= rad_ff << 2;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 5'(LEN_W - 1)) begin
                  comp_ff  <= '0;
                  state_ff <= S_DINIT;
               end
            end
            S_DINIT: begin
               // quotient stays below 2^15, so the top part is below the divisor
               rdiv_ff  <= LEN_W'(num[NUM_W-1:Q_W]);
               nlo_ff   <= num[Q_W-1:0];
               q_ff     <= '0;
               cnt_ff   <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (r_t >= {1'b0, root_ff}) begin
                  rdiv_ff <= LEN_W'(r_t - {1'b0, root_ff});
               end else begin
                  rdiv_ff <= LEN_W'(r_t);
               end
               nlo_ff <= nlo_ff << 1;
               q_ff   <= q_in;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 5'(Q_W - 1)) begin
                  res_ff.n[comp_ff] <= neg_ff[comp_ff] ? NORM_W'(0) - NORM_W'(q_in)
                                                       : NORM_W'(q_in);
                  if (comp_ff == 2'd2) begin
                     res_ff.zero <= 1'b0;
                     done_ff     <= 1'b1;
                     state_ff    <= S_IDLE;
                  end else begin
                     comp_ff  <= comp_ff + 1'b1;
                     state_ff <= S_DINIT;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

### rtl/core/svna_engine.sv
// ----------------------------------------------------------------------------
// svna_engine
// Back end: vertex and sum memories, clearing pass, cross product,
// accumulator updates and the result register.
// ----------------------------------------------------------------------------
module svna_engine import svna_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  req_type q_item,
   output logic    q_pop,
   output logic    clearing,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   typedef enum logic [3:0] {
      E_CLEAR, E_IDLE, E_WRITE, E_RDC, E_RDA, E_RDB, E_EB, E_MUL, E_TGO,
      E_TWAIT, E_ARD, E_AWR, E_RDS, E_RGO, E_RWAIT, E_OUT
   } state_type;

   typedef logic [2:0][COORD_W-1:0]  vword_type;
   typedef logic [2:0][SUM_BITS-1:0] sword_type;

   vword_type vmem [VERTEX_DEPTH];
   sword_type smem [VERTEX_DEPTH];

   state_type              state_ff;
   logic [ADDR_W-1:0]      clr_ff;
   req_type                cmd_ff;
   vword_type              vrd_ff;
   sword_type              srd_ff;
   logic [2:0][EDGE_W-1:0] vc_ff, e0_ff, e1_ff;
   logic signed [PROD_W-1:0] prod_ff, hold_ff;
   logic [2:0][NV_W-1:0]   cr_ff;
   logic [2:0]             mcnt_ff;
   logic [1:0]             k_ff;
   logic [2:0][NORM_W-1:0] n_ff;
   rsp_type                pend_ff;
   logic                   out_valid_ff;
   rsp_type                out_ff;

   logic                   v_we, s_we;
   logic [ADDR_W-1:0]      v_waddr, v_raddr, s_waddr, s_raddr;
   vword_type              v_wdata;
   sword_type              s_wdata;
   logic [EDGE_W-1:0]      op_a, op_b;
   logic [2:0]             mprev;
   logic [IDX_W-1:0]       corner;
   logic                   norm_start, norm_done;
   logic [2:0][NV_W-1:0]   norm_vec;
   norm_res_type           norm_res;

   function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] s,
                                                   input logic [NORM_W-1:0] n);
      logic [SUM_BITS:0] t;
      t = (SUM_BITS+1)'($signed(s)) + (SUM_BITS+1)'($signed(n));
      if (t[SUM_BITS] != t[SUM_BITS-1]) begin
         return {t[SUM_BITS], {(SUM_BITS-1){!t[SUM_BITS]}}};
      end
      return t[SUM_BITS-1:0];
   endfunction

   assign clearing = (state_ff == E_CLEAR);
   assign q_pop    = (state_ff == E_IDLE) && !q_empty;
   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

   always_comb begin
      case (k_ff)
         2'd0:    corner = cmd_ff.corner_a;
         2'd1:    corner = cmd_ff.corner_b;
         default: corner = cmd_ff.corner_c;
      endcase
      case (mcnt_ff)
         3'd0:    begin op_a = e0_ff[1]; op_b = e1_ff[2]; end
         3'd1:    begin op_a = e0_ff[2]; op_b = e1_ff[1]; end
         3'd2:    begin op_a = e0_ff[2]; op_b = e1_ff[0]; end
         3'd3:    begin op_a = e0_ff[0]; op_b = e1_ff[2]; end
         3'd4:    begin op_a = e0_ff[0]; op_b = e1_ff[1]; end
         3'd5:    begin op_a = e0_ff[1]; op_b = e1_ff[0]; end
         default: begin op_a = '0;       op_b = '0;       end
      endcase
      mprev = mcnt_ff - 1'b1;

      v_we    = 1'b0;
      s_we    = 1'b0;
      v_waddr = ADDR_W'(cmd_ff.vertex_index);
      s_waddr = ADDR_W'(cmd_ff.vertex_index);
      v_wdata = {cmd_ff.coord_z, cmd_ff.coord_y, cmd_ff.coord_x};
      s_wdata = '0;
      v_raddr = ADDR_W'(cmd_ff.corner_c);
      s_raddr = ADDR_W'(cmd_ff.vertex_index);
      case (state_ff)
         E_CLEAR: begin
            v_we    = 1'b1;
            s_we    = 1'b1;
            v_waddr = clr_ff;
            s_waddr = clr_ff;
            v_wdata = '0;
         end
         E_WRITE: begin
            v_we = 1'b1;
            s_we = 1'b1;
         end
         E_RDA:   v_raddr = ADDR_W'(cmd_ff.corner_a);
         E_RDB:   v_raddr = ADDR_W'(cmd_ff.corner_b);
         E_ARD:   s_raddr = ADDR_W'(corner);
         E_AWR: begin
            s_we    = 1'b1;
            s_waddr = ADDR_W'(corner);
            for (int i = 0; i < 3; i++) s_wdata[i] = sat_add(srd_ff[i], n_ff[i]);
         end
         default: ;
      endcase

      norm_start = (state_ff == E_TGO) || (state_ff == E_RGO);
      for (int i = 0; i < 3; i++) begin
         norm_vec[i] = (state_ff == E_RGO) ? NV_W'($signed(srd_ff[i])) : cr_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (v_we) vmem[v_waddr] <= v_wdata;
      vrd_ff <= vmem[v_raddr];
   end

   always_ff @(posedge clock) begin
      if (s_we) smem[s_waddr] <= s_wdata;
      srd_ff <= smem[s_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= E_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         // in E_OUT the output register is reloaded below instead
         if (pop && out_valid_ff && state_ff != E_OUT) out_valid_ff <= 1'b0;
         case (state_ff)
            E_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == ADDR_W'(VERTEX_DEPTH - 1)) state_ff <= E_IDLE;
            end
            E_IDLE: begin
               if (!q_empty) begin
                  cmd_ff <= q_item;
                  case (q_item.command)
                     CMD_WRITE: begin
                        if (in_range(q_item.vertex_index)) state_ff <= E_WRITE;
                     end
                     CMD_TRIANGLE: begin
                        if (in_range(q_item.corner_a) && in_range(q_item.corner_b) &&
                            in_range(q_item.corner_c)) state_ff <= E_RDC;
                     end
                     CMD_READ: begin
                        if (in_range(q_item.vertex_index)) begin
                           state_ff <= E_RDS;
                        end else begin
                           pend_ff.read_index  <= q_item.vertex_index;
                           pend_ff.normal_x    <= '0;
                           pend_ff.normal_y    <= '0;
                           pend_ff.normal_z    <= '0;
                           pend_ff.zero_length <= 1'b1;
                           state_ff            <= E_OUT;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            E_WRITE: state_ff <= E_IDLE;
            E_RDC:   state_ff <= E_RDA;
            E_RDA: begin
               for (int i = 0; i < 3; i++) vc_ff[i] <= EDGE_W'($signed(vrd_ff[i]));
               state_ff <= E_RDB;
            end
            E_RDB: begin
               for (int i = 0; i < 3; i++) begin
                  e0_ff[i] <= EDGE_W'($signed(vrd_ff[i])) - vc_ff[i];
               end
               state_ff <= E_EB;
            end
            E_EB: begin
               for (int i = 0; i < 3; i++) begin
                  e1_ff[i] <= EDGE_W'($signed(vrd_ff[i])) - vc_ff[i];
               end
               mcnt_ff  <= '0;
               state_ff <= E_MUL;
            end
            E_MUL: begin
               // shared multiplier; each cross component is even minus odd product
               prod_ff <= $signed(op_a) * $signed(op_b);
               if (mcnt_ff != '0) begin
                  if (!mprev[0]) begin
                     hold_ff <= prod_ff;
                  end else begin
                     cr_ff[mprev[2:1]] <= NV_W'(hold_ff) - NV_W'(prod_ff);
                  end
               end
               mcnt_ff <= mcnt_ff + 1'b1;
               if (mcnt_ff == 3'd6) state_ff <= E_TGO;
            end
            E_TGO: state_ff <= E_TWAIT;
            E_TWAIT: begin
               if (norm_done) begin
                  n_ff <= norm_res.n;
                  k_ff <= '0;
                  state_ff <= norm_res.zero ? E_IDLE : E_ARD;
               end
            end
            E_ARD: state_ff <= E_AWR;
            E_AWR: begin
               k_ff <= k_ff + 1'b1;
               state_ff <= (k_ff == 2'd2) ? E_IDLE : E_ARD;
            end
            E_RDS: state_ff <= E_RGO;
            E_RGO: state_ff <= E_RWAIT;
            E_RWAIT: begin
               if (norm_done) begin
                  pend_ff.read_index  <= cmd_ff.vertex_index;
                  pend_ff.normal_x    <= norm_res.n[0];
                  pend_ff.normal_y    <= norm_res.n[1];
                  pend_ff.normal_z    <= norm_res.n[2];
                  pend_ff.zero_length <= norm_res.zero;
                  state_ff            <= E_OUT;
               end
            end
            E_OUT: begin
               if (!out_valid_ff || pop) begin
                  out_ff       <= pend_ff;
                  out_valid_ff <= 1'b1;
                  state_ff     <= E_IDLE;
               end
            end
            default: state_ff <= E_IDLE;
         endcase
      end
   end

   svna_norm u_norm (
      .clock (clock),
      .reset (reset),
      .start (norm_start),
      .vec   (norm_vec),
      .done  (norm_done),
      .res   (norm_res)
   );

endmodule

### rtl/core/smooth_vertex_normal_accumulator_top.sv
// ----------------------------------------------------------------------------
// smooth_vertex_normal_accumulator_top
// Averaged vertex normals from triangle face normals.
// ----------------------------------------------------------------------------
// After reset the block clears both memories, one entry per cycle, holding
// full high until every entry is cleared. Commands go into a four-entry
// queue and run one at a time in the engine. A vertex write stores its
// coordinates. A triangle reads its corners and forms the cross product,
// runs one normalize pass, then updates the three corner accumulators. A
// read fetches the sum and runs one normalize pass. The normalize unit does
// one bit of range shift per cycle, then the squares, the square root and
// the three divisions. A finished result sits in an output register, so new
// commands keep entering the queue while it waits to be popped.
module smooth_vertex_normal_accumulator_top import svna_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic    fifo_full, fifo_empty, fifo_pop, clearing;
   req_type fifo_item;

   assign full = fifo_full || clearing;

   svna_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (push && !full),
      .wr_data    (req_data),
      .fifo_full  (fifo_full),
      .rd_en      (fifo_pop),
      .rd_data    (fifo_item),
      .fifo_empty (fifo_empty)
   );

   svna_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (fifo_empty),
      .q_item   (fifo_item),
      .q_pop    (fifo_pop),
      .clearing (clearing),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

### rtl/core/svna_checker.sv
// ----------------------------------------------------------------------------
// svna_checker
// Port-level checks for the vertex normal accumulator.
// ----------------------------------------------------------------------------
module svna_checker import svna_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    push,
   input logic    full,
   input req_type req_data,
   input logic    empty,
   input logic    pop,
   input rsp_type rsp_data
);

   // memories are being cleared right after reset
   a_clear_full: assert property (@(posedge clock) reset |=> full)
      else $error("full low during clearing pass");

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_data))
      else $error("waiting result changed");

   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_data.zero_length |->
         rsp_data.normal_x == '0 && rsp_data.normal_y == '0 && rsp_data.normal_z == '0)
      else $error("zero length result with nonzero normal");

   a_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> $signed(rsp_data.normal_x) <= 16384 &&
                 $signed(rsp_data.normal_x) >= -16384)
      else $error("normal x out of unit range");

endmodule

bind smooth_vertex_normal_accumulator_top svna_checker u_svna_checker (.*);
